// ===== src/fmseq_pkg.sv =====
// Package for the flight mode sequencer: mode and command codes, field widths,
// register reset values and the saturation helper.
// No dependencies.
package fmseq_pkg;

    // Field and register widths.
    localparam int ALT_W   = 21;
    localparam int CMD_W   = 3;
    localparam int DT_W    = 10;
    localparam int REG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int WIDE_W  = ALT_W + 2;
    localparam int PROD_W  = REG_W + DT_W;
    localparam int DEC_W   = 17;

    // Input and output stream widths, padded to whole bytes.
    localparam int S_DATA_W = ((CMD_W + ALT_W + DT_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 + ALT_W + 1 + 7) / 8) * 8;

    // Reciprocal of 1000: (x * DIV_MAGIC) >> DIV_SHIFT equals x / 1000 exactly
    // for every x below 2**27, which covers any rate times interval product.
    localparam int          DIV_SHIFT = 37;
    localparam int          MAGIC_W   = 28;
    localparam logic [27:0] DIV_MAGIC = 28'd137438954;

    // Register reset values.
    localparam logic [REG_W-1:0] CLIMB_STEP_RST   = 16'd1000;
    localparam logic [REG_W-1:0] DESCENT_RATE_RST = 16'd500;
    localparam logic [REG_W-1:0] GROUND_THR_RST   = 16'd50;
    localparam logic [REG_W-1:0] REACH_MARGIN_RST = 16'd100;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_CLIMB_STEP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_DESCENT_RATE = 2'd1;
    localparam logic [IDX_W-1:0] REG_GROUND_THR   = 2'd2;
    localparam logic [IDX_W-1:0] REG_REACH_MARGIN = 2'd3;

    // Request kinds carried on tuser.
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Pilot command codes; the two unused codes act as no command.
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARM      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLIMB    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOITER   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DESCEND  = 3'd5;

    // Flight modes.
    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_HOLD     = 3'd2,
        MODE_CLIMB    = 3'd3,
        MODE_LAND     = 3'd4
    } t_mode;

    // Clamp a widened altitude to the signed 21-bit range.
    function automatic logic signed [ALT_W-1:0] sat_alt(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        lo = -(WIDE_W'(1) <<< (ALT_W - 1));
        hi = (WIDE_W'(1) <<< (ALT_W - 1)) - WIDE_W'(1);
        if (v < lo) begin
            return lo[ALT_W-1:0];
        end else if (v > hi) begin
            return hi[ALT_W-1:0];
        end else begin
            return v[ALT_W-1:0];
        end
    endfunction

endpackage

// ===== src/flight_mode_sequencer.sv =====
// Flight mode sequencer in three register stages: descent product, divide by 1000, update.
// An accepted request passes through stage A, stage B and the result register to the output;
// one request is accepted every cycle while the output side takes results.
// Reset (synchronous, active low) clears the pipeline, sets the mode to disarmed,
// the target to zero and the registers to their default values.
// Depends on fmseq_pkg.
module flight_mode_sequencer
    import fmseq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [REG_W-1:0]    i_cfg_data,
    // Request stream.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata: command [2:0], current_altitude [23:3], tick_interval_ms [33:24]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // tuser: req_type [0]
    input  logic                i_s_axis_tuser,
    // Result stream.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata: flight_mode [2:0], target_altitude [23:3], motors_enabled [24]
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    // Configuration registers.
    logic [REG_W-1:0] r_climb_step;
    logic [REG_W-1:0] r_descent_rate;
    logic [REG_W-1:0] r_ground_thr;
    logic [REG_W-1:0] r_reach_margin;

    // Stage A: captured request and descent product.
    logic                    r_a_valid;
    logic                    r_a_req;
    logic [CMD_W-1:0]        r_a_cmd;
    logic signed [ALT_W-1:0] r_a_alt;
    logic [PROD_W-1:0]       r_a_prod;

    // Stage B: request and descent in whole millimetres.
    logic                    r_b_valid;
    logic                    r_b_req;
    logic [CMD_W-1:0]        r_b_cmd;
    logic signed [ALT_W-1:0] r_b_alt;
    logic [DEC_W-1:0]        r_b_dec;

    // Sequencer state and result register.
    t_mode                   r_mode;
    t_mode                   n_mode;
    logic signed [ALT_W-1:0] r_target;
    logic signed [ALT_W-1:0] n_target;
    logic                    r_out_valid;
    t_mode                   r_out_mode;
    logic signed [ALT_W-1:0] r_out_target;

    logic                                 advance;
    logic [CMD_W-1:0]                     in_cmd;
    logic signed [ALT_W-1:0]              in_alt;
    logic [DT_W-1:0]                      in_dt;
    logic [PROD_W+MAGIC_W-1:0]            div_prod;
    logic signed [WIDE_W-1:0]             alt_w;
    logic signed [WIDE_W-1:0]             tgt_w;
    logic signed [WIDE_W-1:0]             alt_plus_step;
    logic signed [WIDE_W-1:0]             tgt_plus_step;
    logic signed [WIDE_W-1:0]             tgt_minus_margin;
    logic signed [WIDE_W-1:0]             tgt_minus_dec;
    logic signed [WIDE_W-1:0]             ground_w;

    // The whole pipeline moves when the result register is free or being taken.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = advance;

    assign in_cmd = i_s_axis_tdata[CMD_W-1:0];
    assign in_alt = i_s_axis_tdata[CMD_W+ALT_W-1:CMD_W];
    assign in_dt  = i_s_axis_tdata[CMD_W+ALT_W+DT_W-1:CMD_W+ALT_W];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_climb_step   <= CLIMB_STEP_RST;
            r_descent_rate <= DESCENT_RATE_RST;
            r_ground_thr   <= GROUND_THR_RST;
            r_reach_margin <= REACH_MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CLIMB_STEP:   r_climb_step   <= i_cfg_data;
                REG_DESCENT_RATE: r_descent_rate <= i_cfg_data;
                REG_GROUND_THR:   r_ground_thr   <= i_cfg_data;
                REG_REACH_MARGIN: r_reach_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_s_axis_tvalid;
            r_b_valid <= r_a_valid;
        end
    end

    // Stage A: capture the request and form rate times interval.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_req  <= i_s_axis_tuser;
            r_a_cmd  <= in_cmd;
            r_a_alt  <= in_alt;
            r_a_prod <= PROD_W'(r_descent_rate) * PROD_W'(in_dt);
        end
    end

    // Stage B: divide the product by 1000 with the exact reciprocal.
    assign div_prod = (PROD_W+MAGIC_W)'(r_a_prod) * (PROD_W+MAGIC_W)'(DIV_MAGIC);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_req <= r_a_req;
            r_b_cmd <= r_a_cmd;
            r_b_alt <= r_a_alt;
            r_b_dec <= div_prod[DIV_SHIFT+DEC_W-1:DIV_SHIFT];
        end
    end

    // Widened operands for the saturating sums and the compares.
    assign alt_w            = WIDE_W'(r_b_alt);
    assign tgt_w            = WIDE_W'(r_target);
    assign ground_w         = $signed(WIDE_W'(r_ground_thr));
    assign alt_plus_step    = alt_w + $signed(WIDE_W'(r_climb_step));
    assign tgt_plus_step    = tgt_w + $signed(WIDE_W'(r_climb_step));
    assign tgt_minus_margin = tgt_w - $signed(WIDE_W'(r_reach_margin));
    assign tgt_minus_dec    = tgt_w - $signed(WIDE_W'(r_b_dec));

    // Next mode and target for the request in stage B.
    always_comb begin
        n_mode   = r_mode;
        n_target = r_target;
        if (r_b_req == REQ_COMMAND) begin
            if (r_b_cmd == CMD_SHUTDOWN) begin
                n_mode   = MODE_DISARMED;
                n_target = '0;
            end else begin
                case (r_mode)
                    MODE_DISARMED: begin
                        if (r_b_cmd == CMD_ARM) begin
                            n_mode   = MODE_IDLE;
                            n_target = '0;
                        end
                    end
                    MODE_IDLE, MODE_HOLD: begin
                        if (r_b_cmd == CMD_CLIMB) begin
                            n_mode   = MODE_CLIMB;
                            n_target = sat_alt(alt_plus_step);
                        end else if (r_b_cmd == CMD_LOITER && r_mode == MODE_IDLE) begin
                            n_mode   = MODE_HOLD;
                            n_target = r_b_alt;
                        end else if (r_b_cmd == CMD_DESCEND && r_mode == MODE_HOLD) begin
                            n_mode = MODE_LAND;
                        end
                    end
                    MODE_CLIMB: begin
                        if (r_b_cmd == CMD_CLIMB) begin
                            n_target = sat_alt(tgt_plus_step);
                        end else if (r_b_cmd == CMD_LOITER) begin
                            n_mode   = MODE_HOLD;
                            n_target = r_b_alt;
                        end else if (r_b_cmd == CMD_DESCEND) begin
                            n_mode = MODE_LAND;
                        end
                    end
                    MODE_LAND: begin
                        if (r_b_cmd == CMD_LOITER) begin
                            n_mode   = MODE_HOLD;
                            n_target = r_b_alt;
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            case (r_mode)
                MODE_CLIMB: begin
                    // Climb is done once within the margin below the target.
                    if (alt_w >= tgt_minus_margin) begin
                        n_mode = MODE_HOLD;
                    end
                end
                MODE_LAND: begin
                    // Lower the target, never below ground level.
                    if (tgt_minus_dec < 0) begin
                        n_target = '0;
                    end else begin
                        n_target = sat_alt(tgt_minus_dec);
                    end
                    if (alt_w <= ground_w) begin
                        n_mode   = MODE_IDLE;
                        n_target = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DISARMED;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_b_valid;
            if (r_b_valid) begin
                r_mode   <= n_mode;
                r_target <= n_target;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (advance && r_b_valid) begin
            r_out_mode   <= n_mode;
            r_out_target <= n_target;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_DATA_W'({(r_out_mode != MODE_DISARMED),
                                        r_out_target, r_out_mode});

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the flight mode sequencer: a queue-fed request driver,
// a result monitor with an in-line mode and setpoint predictor, and register phases.
// Depends on fmseq_pkg and flight_mode_sequencer.
module testbench;
    import fmseq_pkg::*;

    localparam int     QUIET_LIMIT = 1000;
    localparam longint ALT_LO      = -(longint'(1) << (ALT_W - 1));
    localparam longint ALT_HI      = (longint'(1) << (ALT_W - 1)) - 1;

    // The two command codes with no meaning of their own.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                    kind;
        logic [CMD_W-1:0]        cmd;
        logic signed [ALT_W-1:0] alt;
        logic [DT_W-1:0]         dt;
    } t_flight_req;

    typedef struct packed {
        t_mode                   mode;
        logic signed [ALT_W-1:0] target;
        logic                    motors;
    } t_flight_status;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [REG_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predictor state and its copy of the registers.
    t_mode                   seq_mode = MODE_DISARMED;
    logic signed [ALT_W-1:0] seq_target = '0;
    logic [REG_W-1:0]        cfg_climb_step = CLIMB_STEP_RST;
    logic [REG_W-1:0]        cfg_descent_rate = DESCENT_RATE_RST;
    logic [REG_W-1:0]        cfg_ground_thr = GROUND_THR_RST;
    logic [REG_W-1:0]        cfg_reach_margin = REACH_MARGIN_RST;

    t_flight_req    pending_reqs[$];
    t_flight_status expected_status[$];
    t_flight_req    cur_req = '0;
    logic           req_taken = 1'b0;
    int             req_gap = 0;
    bit             req_steady = 1'b0;
    int             out_stall = 0;
    bit             out_steady = 1'b0;
    int             quiet_cycles = 0;
    int             mismatches = 0;

    flight_mode_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a wide sum to the signed altitude range.
    function automatic logic signed [ALT_W-1:0] clamp_alt(input longint v);
        longint c;
        c = v;
        if (c < ALT_LO) begin
            c = ALT_LO;
        end else if (c > ALT_HI) begin
            c = ALT_HI;
        end
        return c[ALT_W-1:0];
    endfunction

    // Apply one request to the predicted mode and setpoint and return the status.
    function automatic t_flight_status advance_sequencer(input t_flight_req r);
        t_flight_status s;
        longint         alt;
        longint         dec;
        longint         t;
        alt = longint'($signed(r.alt));
        if (r.kind == REQ_COMMAND) begin
            if (r.cmd == CMD_SHUTDOWN) begin
                seq_mode = MODE_DISARMED;
                seq_target = '0;
            end else begin
                case (seq_mode)
                    MODE_DISARMED: begin
                        if (r.cmd == CMD_ARM) begin
                            seq_mode = MODE_IDLE;
                            seq_target = '0;
                        end
                    end
                    MODE_IDLE, MODE_HOLD: begin
                        if (r.cmd == CMD_CLIMB) begin
                            seq_mode = MODE_CLIMB;
                            seq_target = clamp_alt(alt + longint'(cfg_climb_step));
                        end else if (r.cmd == CMD_LOITER && seq_mode == MODE_IDLE) begin
                            seq_mode = MODE_HOLD;
                            seq_target = r.alt;
                        end else if (r.cmd == CMD_DESCEND && seq_mode == MODE_HOLD) begin
                            seq_mode = MODE_LAND;
                        end
                    end
                    MODE_CLIMB: begin
                        if (r.cmd == CMD_CLIMB) begin
                            seq_target = clamp_alt(longint'(seq_target)
                                                   + longint'(cfg_climb_step));
                        end else if (r.cmd == CMD_LOITER) begin
                            seq_mode = MODE_HOLD;
                            seq_target = r.alt;
                        end else if (r.cmd == CMD_DESCEND) begin
                            seq_mode = MODE_LAND;
                        end
                    end
                    MODE_LAND: begin
                        if (r.cmd == CMD_LOITER) begin
                            seq_mode = MODE_HOLD;
                            seq_target = r.alt;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (seq_mode == MODE_CLIMB) begin
            if (alt >= longint'(seq_target) - longint'(cfg_reach_margin)) begin
                seq_mode = MODE_HOLD;
            end
        end else if (seq_mode == MODE_LAND) begin
            // Fractional millimetres of the decrement are dropped.
            dec = longint'(cfg_descent_rate) * longint'(r.dt) / 1000;
            t = longint'(seq_target) - dec;
            if (t < 0) begin
                t = 0;
            end
            seq_target = clamp_alt(t);
            if (alt <= longint'(cfg_ground_thr)) begin
                seq_mode = MODE_IDLE;
                seq_target = '0;
            end
        end
        s.mode = seq_mode;
        s.target = seq_target;
        s.motors = (seq_mode != MODE_DISARMED);
        return s;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return $urandom_range(1, 2);
        end else if (sel < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 50);
    endfunction

    // Altitudes cluster near the ground and low heights, with some full-range values.
    function automatic logic signed [ALT_W-1:0] pick_altitude();
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            v = int'($urandom_range(0, 400)) - 150;
        end else if (sel < 70) begin
            v = int'($urandom_range(0, 6000));
        end else if (sel < 85) begin
            v = int'($urandom());
        end else if (sel < 90) begin
            v = $urandom_range(0, 1) ? int'(ALT_HI) : int'(ALT_LO);
        end else if ($urandom_range(0, 1)) begin
            v = int'(ALT_HI) - int'($urandom_range(0, 3000));
        end else begin
            v = int'(ALT_LO) + int'($urandom_range(0, 3000));
        end
        return v[ALT_W-1:0];
    endfunction

    function automatic logic [DT_W-1:0] pick_interval();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
            return DT_W'($urandom_range(0, 1000));
        end else if (sel < 9) begin
            return DT_W'($urandom_range(1001, 1023));
        end
        return DT_W'($urandom_range(0, 20));
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int alt);
        t_flight_req r;
        r.kind = REQ_COMMAND;
        r.cmd = cmd;
        r.alt = alt[ALT_W-1:0];
        r.dt = DT_W'($urandom());
        pending_reqs.push_back(r);
    endtask

    task automatic push_tick(input int alt, input int dt);
        t_flight_req r;
        r.kind = REQ_TICK;
        r.cmd = CMD_W'($urandom());
        r.alt = alt[ALT_W-1:0];
        r.dt = dt[DT_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // Hand-picked walk through every mode, the saturation edges and the rounding.
    task automatic queue_directed();
        push_cmd(CMD_CLIMB, 0);
        push_cmd(CMD_SPARE_HI, 0);
        push_cmd(CMD_ARM, 0);
        push_tick(0, 1023);
        push_cmd(CMD_LOITER, int'(ALT_LO));
        push_cmd(CMD_DESCEND, 0);
        push_tick(int'(ALT_HI), 1000);
        push_cmd(CMD_LOITER, int'(ALT_HI));
        push_cmd(CMD_CLIMB, int'(ALT_HI));
        push_cmd(CMD_CLIMB, 0);
        push_tick(int'(ALT_HI) - 100, 5);
        push_cmd(CMD_CLIMB, 0);
        push_tick(899, 0);
        push_tick(900, 0);
        push_cmd(CMD_SPARE_LO, 0);
        push_cmd(CMD_DESCEND, 0);
        push_tick(500, 1023);
        push_tick(51, 1);
        push_tick(50, 0);
        push_cmd(CMD_NONE, 0);
        push_cmd(CMD_DESCEND, 0);
        push_cmd(CMD_CLIMB, int'(ALT_LO));
        push_cmd(CMD_DESCEND, 0);
        push_tick(int'(ALT_LO), 2);
        push_cmd(CMD_SHUTDOWN, 0);
    endtask

    // Random flight: arm often, disarm seldom, so most requests reach the deep modes.
    task automatic queue_random(input int count);
        int unsigned sel;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 45) begin
                push_tick(int'($signed(pick_altitude())), int'(pick_interval()));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 15) cmd = CMD_ARM;
                else if (sel < 19) cmd = CMD_SHUTDOWN;
                else if (sel < 44) cmd = CMD_CLIMB;
                else if (sel < 62) cmd = CMD_LOITER;
                else if (sel < 82) cmd = CMD_DESCEND;
                else if (sel < 92) cmd = CMD_NONE;
                else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                push_cmd(cmd, int'($signed(pick_altitude())));
            end
        end
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_status.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_CLIMB_STEP:   cfg_climb_step = val;
            REG_DESCENT_RATE: cfg_descent_rate = val;
            REG_GROUND_THR:   cfg_ground_thr = val;
            REG_REACH_MARGIN: cfg_reach_margin = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Reprogram all registers once the pipeline has emptied.
    task automatic apply_profile(input int step, input int rate, input int gnd, input int margin);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(REG_CLIMB_STEP, REG_W'(step));
        write_reg(REG_DESCENT_RATE, REG_W'(rate));
        write_reg(REG_GROUND_THR, REG_W'(gnd));
        write_reg(REG_REACH_MARGIN, REG_W'(margin));
    endtask

    // Request driver: presents queued requests at the falling edge with random gaps.
    always @(negedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (req_gap > 0) begin
                req_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= {{(S_DATA_W - CMD_W - ALT_W - DT_W){1'b0}},
                            cur_req.dt, cur_req.alt, cur_req.cmd};
                s_tuser <= cur_req.kind;
                s_valid <= 1'b1;
                if ($urandom_range(0, 63) == 0) begin
                    req_steady = !req_steady;
                end
                req_gap = (req_steady || $urandom_range(0, 1)) ? 0 : idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls on tready, with quiet stretches of none.
    always @(negedge i_clk) begin : result_ready_driver
        if ($urandom_range(0, 127) == 0) begin
            out_steady = !out_steady;
        end
        if (out_stall == 0 && !out_steady && $urandom_range(0, 3) == 0) begin
            out_stall = idle_len();
        end
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest prediction, predicts each request.
    always @(posedge i_clk) begin : status_monitor
        t_flight_status want;
        t_flight_status got;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                got.mode = t_mode'(m_tdata[2:0]);
                got.target = m_tdata[ALT_W+2:3];
                got.motors = m_tdata[ALT_W+3];
                if (expected_status.size() == 0) begin
                    $display("%0t: result with nothing expected: mode %0d target %0d motors %0b",
                             $time, got.mode, $signed(got.target), got.motors);
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.mode != want.mode) begin
                        $display("%0t: flight_mode expected %0d, got %0d",
                                 $time, want.mode, got.mode);
                        mismatches++;
                    end
                    if (got.target != want.target) begin
                        $display("%0t: target_altitude expected %0d, got %0d",
                                 $time, $signed(want.target), $signed(got.target));
                        mismatches++;
                    end
                    if (got.motors != want.motors) begin
                        $display("%0t: motors_enabled expected %0b, got %0b",
                                 $time, want.motors, got.motors);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_status.push_back(advance_sequencer(cur_req));
            end
            // Watchdog on handshakes in either direction.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles",
                         $time, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Phases: defaults, all registers at zero, all at maximum, random, and small values.
    initial begin : run_phases
        bit clean;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        queue_random(200);
        apply_profile(0, 0, 0, 0);
        queue_random(150);
        apply_profile(65535, 65535, 65535, 65535);
        queue_random(150);
        apply_profile($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_random(200);
        apply_profile($urandom_range(0, 3000), $urandom_range(0, 5000),
                      $urandom_range(0, 500), $urandom_range(0, 500));
        queue_random(250);
        wait_drained();
        repeat (8) @(posedge i_clk);
        clean = (mismatches == 0) && (expected_status.size() == 0);
        if (expected_status.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_status.size());
        end
        if (clean) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
